FILE: sv/mips_instruction_step_core_top_defines.svh
// assertion macros for the step core, used by the controller module
// expects signals named clk and arst_n in the module that uses them
`ifndef MIPS_INSTRUCTION_STEP_CORE_TOP_DEFINES_SVH
`define MIPS_INSTRUCTION_STEP_CORE_TOP_DEFINES_SVH

// same-cycle implication
`define MIS_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("step core check failed");

// next-cycle implication
`define MIS_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("step core check failed");

`endif

FILE: sv/mis_pkg.sv
// types and codes for the mips instruction step core
// used by the controller, datapath and top level
package mis_pkg;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_INVALID = 3'd1;
	localparam logic [2:0] STS_HALT    = 3'd2;
	localparam logic [2:0] STS_PAST    = 3'd3;
	localparam logic [2:0] STS_DIV0    = 3'd4;

	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_JAL   = 6'h03;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_BLEZ  = 6'h06;
	localparam logic [5:0] OPC_BGTZ  = 6'h07;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_SLTI  = 6'h0A;
	localparam logic [5:0] OPC_SLTIU = 6'h0B;
	localparam logic [5:0] OPC_ANDI  = 6'h0C;
	localparam logic [5:0] OPC_ORI   = 6'h0D;
	localparam logic [5:0] OPC_XORI  = 6'h0E;
	localparam logic [5:0] OPC_LUI   = 6'h0F;
	localparam logic [5:0] OPC_LB    = 6'h20;
	localparam logic [5:0] OPC_LH    = 6'h21;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_LHU   = 6'h25;
	localparam logic [5:0] OPC_SB    = 6'h28;
	localparam logic [5:0] OPC_SH    = 6'h29;
	localparam logic [5:0] OPC_SW    = 6'h2B;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	localparam logic [4:0]  REG_V0    = 5'd2;
	localparam logic [4:0]  REG_RA    = 5'd31;
	localparam logic [31:0] EXIT_CODE = 32'd10;
	localparam logic [14:0] DSS_RESET = 15'd8192;

	typedef struct packed {
		logic idle;
		logic accept;
		logic fetch;
		logic decode;
		logic exec;
		logic load_out;
	} mis_cmd_t;

	typedef struct packed {
		logic short_path;
		logic div_wait;
		logic div_done;
	} mis_sts_t;

endpackage

FILE: sv/mis_div.sv
// iterative unsigned divider, one quotient bit per cycle
// standalone, used by the datapath
module mis_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem[31:0], quo[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem   <= '0;
			quo   <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem <= trial[31:0];
				quo <= {quo[30:0], 1'b1};
			end else begin
				rem <= {rem[30:0], quo[31]};
				quo <= {quo[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
endmodule

FILE: sv/mis_ctrl.sv
// sequencing controller for the step core
// depends on mis_pkg and the assertion macro header
`include "mips_instruction_step_core_top_defines.svh"
module mis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mis_pkg::mis_sts_t sts,
	output mis_pkg::mis_cmd_t cmd
);
	import mis_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_DIVW   = 3'd3;
	localparam logic [2:0] ST_EXEC   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       acc;
	logic       can_load;

	assign acc      = in_valid && (state_q == ST_IDLE);
	assign can_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.idle     = (state_q == ST_IDLE);
		cmd.accept   = acc;
		cmd.fetch    = (state_q == ST_FETCH);
		cmd.decode   = (state_q == ST_DECODE);
		cmd.exec     = (state_q == ST_EXEC);
		cmd.load_out = can_load;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) state_d = sts.short_path ? ST_FINISH : ST_FETCH;
			end
			ST_FETCH:  state_d = ST_DECODE;
			ST_DECODE: state_d = sts.div_wait ? ST_DIVW : ST_EXEC;
			ST_DIVW: begin
				if (sts.div_done) state_d = ST_EXEC;
			end
			ST_EXEC:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (can_load) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (can_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`MIS_ASSERT_NEXT(a_accept_leaves_idle, acc, state_q != ST_IDLE)
	`MIS_ASSERT_NEXT(a_out_holds, out_valid_q && out_stall, out_valid_q)
	`MIS_ASSERT_NEXT(a_divw_exit, state_q == ST_DIVW,
		state_q == ST_DIVW || state_q == ST_EXEC)
endmodule

FILE: sv/mis_dp.sv
// datapath of the step core: pc, register file, hi/lo, memory, alu, result
// depends on mis_pkg and mis_div
module mis_dp #(
	parameter int MEM_WORDS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mis_pkg::mis_cmd_t cmd,
	output mis_pkg::mis_sts_t sts,
	input  logic              cfg_we,
	input  logic [14:0]       cfg_data,
	input  logic              op,
	input  logic [11:0]       word_index,
	input  logic [31:0]       word_data,
	output logic [2:0]        status,
	output logic [31:0]       pc_after,
	output logic [31:0]       instruction,
	output logic              reg_written,
	output logic [4:0]        reg_index,
	output logic [31:0]       reg_value,
	output logic              mem_written
);
	import mis_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rf  [32];
	logic [31:0] rf_vld_q;

	logic [31:0] pc_q, hi_q, lo_q, instr_q, a_q, b_q, addr_q, rd_q;
	logic [63:0] prod_q;
	logic [14:0] dss_q;
	logic        halted_q;
	logic [31:0] rfa_d, rfb_d;
	logic        rfa_v, rfb_v;

	logic [2:0]  res_status_q;
	logic [31:0] res_pc_q, res_instr_q, res_val_q;
	logic        res_wreg_q, res_wmem_q;
	logic [4:0]  res_idx_q;

	logic        short_path, idx_ok;
	logic [4:0]  rs_sel, rt_sel;
	logic [31:0] a_w, b_w, addr_w;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          mem_we;
	logic [31:0]   mem_wd;

	logic [5:0]  opc, fn;
	logic [4:0]  rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] simm, pc4, br_tgt, j_tgt;
	logic [4:0]  boff, hoff;

	logic [2:0]  x_status;
	logic [31:0] x_pc, x_val, x_store, x_hi, x_lo;
	logic [4:0]  x_idx;
	logic        x_wreg, x_wmem, x_hilo, x_halt;

	logic        div_start, div_done;
	logic [31:0] div_q, div_r, ma_w, mb_w;

	assign idx_ok     = (32'(word_index) < 32'(MEM_WORDS));
	assign short_path = !op || halted_q || (pc_q >= 32'(dss_q));

	assign rs_sel = (rd_q[31:26] == OPC_RTYPE && rd_q[5:0] == FN_SYSCALL) ? REG_V0 : rd_q[25:21];
	assign rt_sel = rd_q[20:16];
	assign a_w    = rfa_v ? rfa_d : '0;
	assign b_w    = rfb_v ? rfb_d : '0;

	assign opc  = instr_q[31:26];
	assign rt   = instr_q[20:16];
	assign rd   = instr_q[15:11];
	assign sh   = instr_q[10:6];
	assign fn   = instr_q[5:0];
	assign imm  = instr_q[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign addr_w = a_w + simm;
	assign pc4    = pc_q + 32'd4;
	assign br_tgt = pc4 + {simm[29:0], 2'b00};
	assign j_tgt  = {pc4[31:28], instr_q[25:0], 2'b00};
	assign boff   = {addr_q[1:0], 3'b000};
	assign hoff   = {addr_q[1], 4'b0000};

	assign ma_w = a_w[31] ? (32'd0 - a_w) : a_w;
	assign mb_w = b_w[31] ? (32'd0 - b_w) : b_w;
	assign div_start = cmd.decode && sts.div_wait;

	assign sts.short_path = short_path;
	assign sts.div_wait   = (opc == OPC_RTYPE) && (fn == FN_DIV) && (b_w != '0);
	assign sts.div_done   = div_done;

	mis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ma_w),
		.divisor  (mb_w),
		.done     (div_done),
		.quo      (div_q),
		.rem      (div_r)
	);

	always_comb begin
		if (cmd.idle) rd_addr = pc_q[AW+1:2];
		else if (cmd.decode) rd_addr = addr_w[AW+1:2];
		else rd_addr = addr_q[AW+1:2];
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = addr_q[AW+1:2];
		mem_wd  = x_store;
		if (cmd.accept && !op && idx_ok) begin
			mem_we  = 1'b1;
			wr_addr = AW'(word_index);
			mem_wd  = word_data;
		end else if (cmd.exec && x_wmem) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && x_wreg) rf[x_idx] <= x_val;
		rfa_d <= rf[rs_sel];
		rfb_d <= rf[rt_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			rfa_v    <= 1'b0;
			rfb_v    <= 1'b0;
		end else begin
			if (cmd.exec && x_wreg) rf_vld_q[x_idx] <= 1'b1;
			rfa_v <= rf_vld_q[rs_sel];
			rfb_v <= rf_vld_q[rt_sel];
		end
	end

	always_comb begin
		x_status = STS_OK;
		x_pc     = pc4;
		x_wreg   = 1'b0;
		x_idx    = rt;
		x_val    = '0;
		x_wmem   = 1'b0;
		x_store  = b_q;
		x_hilo   = 1'b0;
		x_hi     = hi_q;
		x_lo     = lo_q;
		x_halt   = 1'b0;
		unique case (opc)
			OPC_RTYPE: begin
				x_idx  = rd;
				x_wreg = 1'b1;
				unique case (fn)
					FN_SLL: x_val = b_q << sh;
					FN_SRL: x_val = b_q >> sh;
					FN_SRA: x_val = 32'($signed(b_q) >>> sh);
					FN_JR: begin
						x_wreg = 1'b0;
						x_pc   = a_q;
					end
					FN_SYSCALL: begin
						x_wreg = 1'b0;
						if (a_q == EXIT_CODE) begin
							x_halt   = 1'b1;
							x_status = STS_HALT;
						end
					end
					FN_MULT: begin
						x_wreg = 1'b0;
						x_hilo = 1'b1;
						x_hi   = prod_q[63:32];
						x_lo   = prod_q[31:0];
					end
					FN_DIV: begin
						x_wreg = 1'b0;
						x_hilo = 1'b1;
						if (b_q == '0) begin
							x_lo     = '1;
							x_hi     = a_q;
							x_status = STS_DIV0;
						end else begin
							x_lo = (a_q[31] != b_q[31]) ? (32'd0 - div_q) : div_q;
							x_hi = a_q[31] ? (32'd0 - div_r) : div_r;
						end
					end
					FN_ADD, FN_ADDU: x_val = a_q + b_q;
					FN_SUB: x_val = a_q - b_q;
					FN_AND: x_val = a_q & b_q;
					FN_OR:  x_val = a_q | b_q;
					FN_XOR: x_val = a_q ^ b_q;
					FN_NOR: x_val = ~(a_q | b_q);
					FN_SLT: x_val = {31'd0, $signed(a_q) < $signed(b_q)};
					default: begin
						x_wreg   = 1'b0;
						x_status = STS_INVALID;
					end
				endcase
			end
			OPC_JAL: begin
				x_wreg = 1'b1;
				x_idx  = REG_RA;
				x_val  = pc4;
				x_pc   = j_tgt;
			end
			OPC_J:    x_pc = j_tgt;
			OPC_BEQ:  if (a_q == b_q) x_pc = br_tgt;
			OPC_BNE:  if (a_q != b_q) x_pc = br_tgt;
			OPC_BLEZ: if (a_q == '0 || a_q[31]) x_pc = br_tgt;
			OPC_BGTZ: if (a_q != '0 && !a_q[31]) x_pc = br_tgt;
			OPC_ADDI, OPC_ADDIU: begin
				x_wreg = 1'b1;
				x_val  = a_q + simm;
			end
			OPC_SLTI: begin
				x_wreg = 1'b1;
				x_val  = {31'd0, $signed(a_q) < $signed(simm)};
			end
			OPC_SLTIU: begin
				x_wreg = 1'b1;
				x_val  = {31'd0, a_q < simm};
			end
			OPC_ANDI: begin
				x_wreg = 1'b1;
				x_val  = a_q & {16'd0, imm};
			end
			OPC_ORI: begin
				x_wreg = 1'b1;
				x_val  = a_q | {16'd0, imm};
			end
			OPC_XORI: begin
				x_wreg = 1'b1;
				x_val  = a_q ^ {16'd0, imm};
			end
			OPC_LUI: begin
				x_wreg = 1'b1;
				x_val  = {imm, 16'd0};
			end
			OPC_LB: begin
				x_wreg = 1'b1;
				x_val  = {{24{rd_q[boff+7]}}, rd_q[boff +: 8]};
			end
			OPC_LH: begin
				x_wreg = 1'b1;
				x_val  = {{16{rd_q[hoff+15]}}, rd_q[hoff +: 16]};
			end
			OPC_LHU: begin
				x_wreg = 1'b1;
				x_val  = {16'd0, rd_q[hoff +: 16]};
			end
			OPC_LW: begin
				x_wreg = 1'b1;
				x_val  = rd_q;
			end
			OPC_SB: begin
				x_wmem  = 1'b1;
				x_store = rd_q;
				x_store[boff +: 8] = b_q[7:0];
			end
			OPC_SH: begin
				x_wmem  = 1'b1;
				x_store = rd_q;
				x_store[hoff +: 16] = b_q[15:0];
			end
			OPC_SW: x_wmem = 1'b1;
			default: x_status = STS_INVALID;
		endcase
		if (x_wreg && x_idx == 5'd0) x_wreg = 1'b0;
		if (!x_wreg) begin
			x_idx = '0;
			x_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			halted_q <= 1'b0;
			dss_q    <= DSS_RESET;
		end else begin
			if (cfg_we) dss_q <= cfg_data;
			if (cmd.exec) begin
				pc_q <= x_pc;
				if (x_hilo) begin
					hi_q <= x_hi;
					lo_q <= x_lo;
				end
				if (x_halt) halted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) instr_q <= rd_q;
		if (cmd.decode) begin
			a_q    <= a_w;
			b_q    <= b_w;
			addr_q <= addr_w;
			prod_q <= 64'($signed(a_w) * $signed(b_w));
		end
		if (cmd.accept && short_path) begin
			res_pc_q    <= pc_q;
			res_instr_q <= '0;
			res_wreg_q  <= 1'b0;
			res_idx_q   <= '0;
			res_val_q   <= '0;
			res_wmem_q  <= !op && idx_ok;
			priority if (!op) res_status_q <= STS_OK;
			else if (halted_q) res_status_q <= STS_HALT;
			else res_status_q <= STS_PAST;
		end else if (cmd.exec) begin
			res_status_q <= x_status;
			res_pc_q     <= x_pc;
			res_instr_q  <= instr_q;
			res_wreg_q   <= x_wreg;
			res_idx_q    <= x_idx;
			res_val_q    <= x_val;
			res_wmem_q   <= x_wmem;
		end
		if (cmd.load_out) begin
			status      <= res_status_q;
			pc_after    <= res_pc_q;
			instruction <= res_instr_q;
			reg_written <= res_wreg_q;
			reg_index   <= res_idx_q;
			reg_value   <= res_val_q;
			mem_written <= res_wmem_q;
		end
	end
endmodule

FILE: sv/mips_instruction_step_core_top.sv
// MIPS32 subset step core. Each accepted request is a memory word write
// (op 0) or one instruction step (op 1) and gives one result. A memory write
// or a refused step (halted, past data segment) skips the instruction steps
// and goes to the output register; an instruction step goes through fetch read,
// register read, operand/address and multiply stage, execute and result, and a
// div with a nonzero divisor waits on the one-bit-per-cycle divider. One request
// is in work at a time; the output register frees the input side while a result waits.
// Depends on mis_pkg, mis_ctrl, mis_dp, mis_div.
module mips_instruction_step_core_top #(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [11:0] word_index,
	input  logic [31:0] word_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] pc_after,
	output logic [31:0] instruction,
	output logic        reg_written,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_written,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);
	import mis_pkg::*;

	mis_cmd_t cmd;
	mis_sts_t sts;

	assign cfg_ready = 1'b1;

	mis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mis_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.op          (op),
		.word_index  (word_index),
		.word_data   (word_data),
		.status      (status),
		.pc_after    (pc_after),
		.instruction (instruction),
		.reg_written (reg_written),
		.reg_index   (reg_index),
		.reg_value   (reg_value),
		.mem_written (mem_written)
	);
endmodule

FILE: bench/mips_instruction_step_core_top_tb.sv
// self-checking bench for mips_instruction_step_core_top: a directed table, then random
// programs written word by word at the pc, checked against an in-bench model of the core
// depends on mis_pkg and the step core rtl
module mips_instruction_step_core_top_tb;
	import mis_pkg::*;

	localparam int PC_LIMIT  = 3900;
	localparam int DATA_BASE = 8192;
	localparam logic [5:0] BAD_OPC_A = 6'h01;
	localparam logic [5:0] BAD_OPC_B = 6'h3F;
	localparam logic [5:0] BAD_FN    = 6'h3F;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pc;
		logic [31:0] instr;
		logic        rw;
		logic [4:0]  ridx;
		logic [31:0] rval;
		logic        mw;
	} step_result_t;

	typedef struct {
		logic         o;
		logic [11:0]  idx;
		logic [31:0]  data;
		logic         lit;
		step_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [11:0] word_index = '0;
	logic [31:0] word_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] pc_after;
	logic [31:0] instruction;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_written;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data = '0;

	logic [31:0] core_pc;
	logic [31:0] core_regs [0:31];
	logic [31:0] core_hi, core_lo;
	logic [31:0] core_mem [0:4095];
	logic        core_halted;
	logic [14:0] core_dss;

	step_result_t pending_results [$];
	stim_row_t    stim_rows [$];
	int           mismatches = 0;
	int           gap_odds = 3;
	int           stall_left = 0;
	logic         calm = 1'b0;

	mips_instruction_step_core_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .word_index(word_index), .word_data(word_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pc_after(pc_after), .instruction(instruction),
		.reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
		.mem_written(mem_written),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic core_step(input logic o, input logic [11:0] wi, input logic [31:0] wd,
			output step_result_t r);
		logic [31:0] ins, a, b, simm, addr, wv, tmp, ma, mb, q, rm;
		logic [5:0] opc, fn;
		logic [4:0] rs, rt, rd, sh, wx, bs, hs;
		logic [11:0] wa;
		logic wr, memw;
		logic [63:0] prod;
		r = '0;
		ins = '0; wr = 1'b0; wx = '0; wv = '0; memw = 1'b0;
		r.status = STS_OK;
		if (!o) begin
			core_mem[wi] = wd;
			memw = 1'b1;
		end else if (core_halted) begin
			r.status = STS_HALT;
		end else if (core_pc >= {17'd0, core_dss}) begin
			r.status = STS_PAST;
		end else begin
			ins = core_mem[core_pc[13:2]];
			core_pc = core_pc + 32'd4;
			opc = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
			rd = ins[15:11]; sh = ins[10:6]; fn = ins[5:0];
			simm = {{16{ins[15]}}, ins[15:0]};
			a = core_regs[rs]; b = core_regs[rt];
			addr = a + simm;
			wa = addr[13:2];
			bs = {addr[1:0], 3'b000};
			hs = {addr[1], 4'b0000};
			case (opc)
				OPC_RTYPE: begin
					wr = 1'b1; wx = rd;
					case (fn)
						FN_SLL: wv = b << sh;
						FN_SRL: wv = b >> sh;
						FN_SRA: wv = $signed(b) >>> sh;
						FN_JR: begin wr = 1'b0; core_pc = a; end
						FN_SYSCALL: begin
							wr = 1'b0;
							if (core_regs[REG_V0] == EXIT_CODE) begin
								core_halted = 1'b1;
								r.status = STS_HALT;
							end
						end
						FN_MULT: begin
							wr = 1'b0;
							prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
							{core_hi, core_lo} = prod;
						end
						FN_DIV: begin
							wr = 1'b0;
							if (b == 32'd0) begin
								core_lo = '1; core_hi = a; r.status = STS_DIV0;
							end else begin
								ma = a[31] ? -a : a;
								mb = b[31] ? -b : b;
								q = ma / mb; rm = ma % mb;
								core_lo = (a[31] ^ b[31]) ? -q : q;
								core_hi = a[31] ? -rm : rm;
							end
						end
						FN_ADD, FN_ADDU: wv = a + b;
						FN_SUB: wv = a - b;
						FN_AND: wv = a & b;
						FN_OR:  wv = a | b;
						FN_XOR: wv = a ^ b;
						FN_NOR: wv = ~(a | b);
						FN_SLT: wv = {31'd0, $signed(a) < $signed(b)};
						default: begin wr = 1'b0; r.status = STS_INVALID; end
					endcase
				end
				OPC_JAL: begin
					wr = 1'b1; wx = REG_RA; wv = core_pc;
					core_pc = {core_pc[31:28], ins[25:0], 2'b00};
				end
				OPC_J: core_pc = {core_pc[31:28], ins[25:0], 2'b00};
				OPC_BEQ: if (a == b) core_pc = core_pc + (simm << 2);
				OPC_BNE: if (a != b) core_pc = core_pc + (simm << 2);
				OPC_BLEZ: if (a == 32'd0 || a[31]) core_pc = core_pc + (simm << 2);
				OPC_BGTZ: if (a != 32'd0 && !a[31]) core_pc = core_pc + (simm << 2);
				OPC_ADDI, OPC_ADDIU: begin wr = 1'b1; wx = rt; wv = a + simm; end
				OPC_SLTI: begin wr = 1'b1; wx = rt; wv = {31'd0, $signed(a) < $signed(simm)}; end
				OPC_SLTIU: begin wr = 1'b1; wx = rt; wv = {31'd0, a < simm}; end
				OPC_ANDI: begin wr = 1'b1; wx = rt; wv = a & {16'd0, ins[15:0]}; end
				OPC_ORI:  begin wr = 1'b1; wx = rt; wv = a | {16'd0, ins[15:0]}; end
				OPC_XORI: begin wr = 1'b1; wx = rt; wv = a ^ {16'd0, ins[15:0]}; end
				OPC_LUI:  begin wr = 1'b1; wx = rt; wv = {ins[15:0], 16'd0}; end
				OPC_LB: begin
					tmp = core_mem[wa] >> bs;
					wr = 1'b1; wx = rt; wv = {{24{tmp[7]}}, tmp[7:0]};
				end
				OPC_LH, OPC_LHU: begin
					tmp = core_mem[wa] >> hs;
					wr = 1'b1; wx = rt;
					wv = (opc == OPC_LH) ? {{16{tmp[15]}}, tmp[15:0]} : {16'd0, tmp[15:0]};
				end
				OPC_LW: begin wr = 1'b1; wx = rt; wv = core_mem[wa]; end
				OPC_SB: begin
					core_mem[wa] = (core_mem[wa] & ~(32'hFF << bs)) | ({24'd0, b[7:0]} << bs);
					memw = 1'b1;
				end
				OPC_SH: begin
					core_mem[wa] = (core_mem[wa] & ~(32'hFFFF << hs)) | ({16'd0, b[15:0]} << hs);
					memw = 1'b1;
				end
				OPC_SW: begin core_mem[wa] = b; memw = 1'b1; end
				default: r.status = STS_INVALID;
			endcase
			if (wr && wx == 5'd0)
				wr = 1'b0;
			if (wr)
				core_regs[wx] = wv;
			else begin
				wx = '0; wv = '0;
			end
		end
		r.pc = core_pc;
		r.instr = ins;
		r.rw = wr;
		r.ridx = wx;
		r.rval = wv;
		r.mw = memw;
	endtask

	function automatic logic [31:0] r_ins(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sh);
		return {OPC_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] i_ins(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	function automatic logic [31:0] make_instr();
		logic [4:0] rs, rt, rd, sh;
		logic [15:0] imm;
		logic [31:0] addr, diff;
		logic [5:0] code;
		int off, tgt, k;
		rs = $urandom; rt = $urandom; rd = $urandom; sh = $urandom; imm = $urandom;
		if (core_pc >= PC_LIMIT)
			return {OPC_J, 26'($urandom_range(0, PC_LIMIT / 4 - 1))};
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				case ($urandom_range(0, 7))
					0: code = FN_ADD;  1: code = FN_ADDU; 2: code = FN_SUB; 3: code = FN_AND;
					4: code = FN_OR;   5: code = FN_XOR;  6: code = FN_NOR; default: code = FN_SLT;
				endcase
				return r_ins(code, rs, rt, rd, 5'd0);
			end
			3: begin
				case ($urandom_range(0, 2))
					0: code = FN_SLL; 1: code = FN_SRL; default: code = FN_SRA;
				endcase
				return r_ins(code, rs, rt, rd, sh);
			end
			4: return r_ins(FN_MULT, rs, rt, 5'd0, 5'd0);
			5: return r_ins(FN_DIV, rs, ($urandom_range(0, 2) == 0) ? 5'd0 : rt, 5'd0, 5'd0);
			6, 7, 8: begin
				case ($urandom_range(0, 7))
					0: code = OPC_ADDI;  1: code = OPC_ADDIU; 2: code = OPC_SLTI; 3: code = OPC_SLTIU;
					4: code = OPC_ANDI;  5: code = OPC_ORI;   6: code = OPC_XORI; default: code = OPC_LUI;
				endcase
				return i_ins(code, rs, rt, imm);
			end
			9: return {OPC_J, 26'($urandom_range(0, PC_LIMIT / 4 - 1))};
			10: return {OPC_JAL, 26'($urandom_range(0, PC_LIMIT / 4 - 1))};
			11: begin
				for (k = 0; k < 32; k++) begin
					if (core_regs[(rs + k) % 32] < PC_LIMIT)
						return r_ins(FN_JR, 5'((rs + k) % 32), 5'd0, 5'd0, 5'd0);
				end
				return {OPC_J, 26'($urandom_range(0, PC_LIMIT / 4 - 1))};
			end
			12, 13: begin
				case ($urandom_range(0, 3))
					0: code = OPC_BEQ; 1: code = OPC_BNE; 2: code = OPC_BLEZ; default: code = OPC_BGTZ;
				endcase
				off = $urandom_range(0, 200) - 100;
				tgt = int'(core_pc) + 4 + off * 4;
				if (tgt < 0 || tgt >= PC_LIMIT)
					off = 0;
				if ($urandom_range(0, 3) == 0)
					rt = rs;
				return i_ins(code, rs, rt, 16'(off));
			end
			14, 15, 16, 17: begin
				addr = DATA_BASE + $urandom_range(0, 255);
				diff = addr - core_regs[rs];
				if (diff[31:15] == '0 || diff[31:15] == '1)
					imm = diff[15:0];
				else begin
					rs = 5'd0; imm = addr[15:0];
				end
				case ($urandom_range(0, 6))
					0: code = OPC_LB; 1: code = OPC_LH; 2: code = OPC_LW; 3: code = OPC_LHU;
					4: code = OPC_SB; 5: code = OPC_SH; default: code = OPC_SW;
				endcase
				return i_ins(code, rs, rt, imm);
			end
			18: begin
				if (core_regs[REG_V0] == EXIT_CODE)
					return 32'd0;
				return r_ins(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0);
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					return r_ins(BAD_FN, rs, rt, rd, sh);
				return i_ins(($urandom_range(0, 1) == 0) ? BAD_OPC_A : BAD_OPC_B, rs, rt, imm);
			end
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance with valid still high
	task automatic send_req(input logic o, input logic [11:0] wi, input logic [31:0] wd,
			input logic lit = 1'b0, input step_result_t typed = '0);
		step_result_t e;
		if (!calm && gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		op <= o;
		word_index <= wi;
		word_data <= wd;
		in_valid <= 1'b1;
		core_step(o, wi, wd, e);
		pending_results.push_back(lit ? typed : e);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic step_with(input logic [31:0] ins);
		send_req(1'b0, core_pc[13:2], ins);
		send_req(1'b1, 12'($urandom), $urandom);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_dss(input logic [14:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		core_dss = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!arst_n || calm)
			out_stall <= 1'b0;
		else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (gap_odds > 0 && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		step_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, pc_after, instruction, reg_written, reg_index, reg_value, mem_written};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request waiting: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.pc !== want.pc || got.instr !== want.instr
						|| got.rw !== want.rw || got.ridx !== want.ridx || got.rval !== want.rval
						|| got.mw !== want.mw) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d pc=%h ins=%h rw=%b ri=%0d rv=%h mw=%b / got st=%0d pc=%h ins=%h rw=%b ri=%0d rv=%h mw=%b",
							want.status, want.pc, want.instr, want.rw, want.ridx, want.rval, want.mw,
							got.status, got.pc, got.instr, got.rw, got.ridx, got.rval, got.mw);
				end
			end
		end
	end

	initial begin
		logic [31:0] w_lui1, w_ori1, w_add, w_div0, w_sltiu, w_lui5, w_divov, w_sra, w_sh, w_lhu;
		logic [31:0] w_r0, w_bad;
		int it;
		core_pc = '0; core_hi = '0; core_lo = '0; core_halted = 1'b0; core_dss = DSS_RESET;
		for (it = 0; it < 32; it++)
			core_regs[it] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// data region used by loads and stores
		for (it = 0; it < 64; it++)
			send_req(1'b0, 12'(DATA_BASE / 4 + it), $urandom);

		w_lui1  = i_ins(OPC_LUI, 5'd0, 5'd1, 16'hFFFF);
		w_ori1  = i_ins(OPC_ORI, 5'd1, 5'd1, 16'hFFFF);
		w_add   = r_ins(FN_ADD, 5'd1, 5'd1, 5'd3, 5'd0);
		w_div0  = r_ins(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0);
		w_bad   = 32'hFFFF_FFFF;
		w_sltiu = i_ins(OPC_SLTIU, 5'd0, 5'd4, 16'hFFFF);
		w_lui5  = i_ins(OPC_LUI, 5'd0, 5'd5, 16'h8000);
		w_divov = r_ins(FN_DIV, 5'd5, 5'd1, 5'd0, 5'd0);
		w_sra   = r_ins(FN_SRA, 5'd0, 5'd5, 5'd6, 5'd31);
		w_sh    = i_ins(OPC_SH, 5'd0, 5'd1, 16'(DATA_BASE + 2));
		w_lhu   = i_ins(OPC_LHU, 5'd0, 5'd7, 16'(DATA_BASE + 3));
		w_r0    = i_ins(OPC_ADDIU, 5'd0, 5'd0, 16'd5);
		stim_rows.push_back('{1'b0, 12'd0, 32'd0, 1'b1, '{STS_OK, 32'd0, 32'd0, 1'b0, 5'd0, 32'd0, 1'b1}});
		stim_rows.push_back('{1'b0, 12'd4095, '1, 1'b1, '{STS_OK, 32'd0, 32'd0, 1'b0, 5'd0, 32'd0, 1'b1}});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_OK, 32'd4, 32'd0, 1'b0, 5'd0, 32'd0, 1'b0}});
		stim_rows.push_back('{1'b0, 12'd1, w_lui1, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd2, w_ori1, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd3, w_add, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd4, w_div0, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_DIV0, 32'd20, w_div0, 1'b0, 5'd0, 32'd0, 1'b0}});
		stim_rows.push_back('{1'b0, 12'd5, w_bad, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_INVALID, 32'd24, w_bad, 1'b0, 5'd0, 32'd0, 1'b0}});
		stim_rows.push_back('{1'b0, 12'd6, w_sltiu, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_OK, 32'd28, w_sltiu, 1'b1, 5'd4, 32'd1, 1'b0}});
		stim_rows.push_back('{1'b0, 12'd7, w_lui5, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd8, w_divov, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_OK, 32'd36, w_divov, 1'b0, 5'd0, 32'd0, 1'b0}});
		stim_rows.push_back('{1'b0, 12'd9, w_sra, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd10, w_sh, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd11, w_lhu, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b0, '0});
		stim_rows.push_back('{1'b0, 12'd12, w_r0, 1'b0, '0});
		stim_rows.push_back('{1'b1, 12'd0, 32'd0, 1'b1, '{STS_OK, 32'd52, w_r0, 1'b0, 5'd0, 32'd0, 1'b0}});
		foreach (stim_rows[i])
			send_req(stim_rows[i].o, stim_rows[i].idx, stim_rows[i].data, stim_rows[i].lit,
				stim_rows[i].res);

		// stepping refused above and at the segment boundary, then allowed just below it
		set_dss(15'd0);
		send_req(1'b1, 12'd0, 32'd0, 1'b1, '{STS_PAST, 32'd52, 32'd0, 1'b0, 5'd0, 32'd0, 1'b0});
		set_dss(core_pc[14:0]);
		send_req(1'b1, '1, '1);
		set_dss(core_pc[14:0] + 15'd4);
		step_with(32'd0);
		set_dss(15'd16384);

		for (it = 0; it < 770; it++) begin
			if (it > 0 && it % 150 == 0) begin
				case (it / 150)
					1: set_dss(15'd4352);
					2: set_dss(15'($urandom_range(4352, 16383)));
					3: set_dss(DSS_RESET);
					default: set_dss(15'd16384);
				endcase
				gap_odds = (it / 150 == 2) ? 0 : $urandom_range(1, 6);
			end
			calm = (it >= 680);
			if ($urandom_range(0, 3) == 0)
				send_req(1'b0, 12'($urandom), $urandom);
			else
				step_with(make_instr());
		end

		step_with(i_ins(OPC_ADDIU, 5'd0, REG_V0, 16'(EXIT_CODE)));
		step_with(r_ins(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
		send_req(1'b1, 12'd0, 32'd0);
		send_req(1'b0, 12'd100, 32'h1234_5678);
		send_req(1'b1, 12'd0, 32'd0);

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
